/* rtl/exr_pkg.sv */
// Package for the Euler x-y-z rotation block: polynomial divisors and
// fixed-point constants for the sine/cosine unit. No dependencies.
package exr_pkg;

    localparam int Q = 30;
    localparam logic [31:0] PI_OVER_4_Q32 = 32'hC90FDAA2;
    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;

    // Reciprocals for the series divisors. For a numerator below 2^31 and
    // 2^L >= d, (n * ceil(2^(31+L) / d)) >> (31+L) is exactly n / d.
    localparam logic [32:0] RCP_110 = 33'(((64'd1 << 38) + 64'd109) / 64'd110);
    localparam logic [32:0] RCP_72  = 33'(((64'd1 << 38) + 64'd71) / 64'd72);
    localparam logic [32:0] RCP_42  = 33'(((64'd1 << 37) + 64'd41) / 64'd42);
    localparam logic [32:0] RCP_20  = 33'(((64'd1 << 36) + 64'd19) / 64'd20);
    localparam logic [32:0] RCP_6   = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
    localparam logic [32:0] RCP_132 = 33'(((64'd1 << 39) + 64'd131) / 64'd132);
    localparam logic [32:0] RCP_90  = 33'(((64'd1 << 38) + 64'd89) / 64'd90);
    localparam logic [32:0] RCP_56  = 33'(((64'd1 << 37) + 64'd55) / 64'd56);
    localparam logic [32:0] RCP_30  = 33'(((64'd1 << 36) + 64'd29) / 64'd30);
    localparam logic [32:0] RCP_12  = 33'(((64'd1 << 35) + 64'd11) / 64'd12);

    // Divisor of each Horner step of the sine series.
    function automatic logic [7:0] sin_div(input int k);
        logic [7:0] d;
        case (k)
            0: d = 8'd110;
            1: d = 8'd72;
            2: d = 8'd42;
            3: d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    // Divisor of each Horner step of the cosine series.
    function automatic logic [7:0] cos_div(input int k);
        logic [7:0] d;
        case (k)
            0: d = 8'd132;
            1: d = 8'd90;
            2: d = 8'd56;
            3: d = 8'd30;
            4: d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // Q1.30 product with rounding: (a*b + 2^29) >> 30.
    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b} + 64'd536870912;
        return p[61:30];
    endfunction

    // Quotient by reciprocal multiplication and a fixed shift.
    function automatic logic [31:0] rcp_mul(input logic [31:0] n, input logic [32:0] m,
                                            input int s);
        logic [64:0] p;
        p = 65'(n) * 65'(m);
        return 32'(p >> s);
    endfunction

    // Rounded quotient (n + d/2) / d for a constant divisor d.
    function automatic logic [31:0] rnd_div(input logic [31:0] n, input logic [7:0] d);
        logic [31:0] q;
        q = 32'd0;
        case (d)
            8'd110: q = rcp_mul(n + 32'd55, RCP_110, 38);
            8'd72:  q = rcp_mul(n + 32'd36, RCP_72, 38);
            8'd42:  q = rcp_mul(n + 32'd21, RCP_42, 37);
            8'd20:  q = rcp_mul(n + 32'd10, RCP_20, 36);
            8'd6:   q = rcp_mul(n + 32'd3, RCP_6, 34);
            8'd132: q = rcp_mul(n + 32'd66, RCP_132, 39);
            8'd90:  q = rcp_mul(n + 32'd45, RCP_90, 38);
            8'd56:  q = rcp_mul(n + 32'd28, RCP_56, 37);
            8'd30:  q = rcp_mul(n + 32'd15, RCP_30, 36);
            8'd12:  q = rcp_mul(n + 32'd6, RCP_12, 35);
            default: q = (n + 32'd1) >> 1;
        endcase
        return q;
    endfunction

endpackage

/* rtl/exr_sincos.sv */
// Pipelined sine/cosine of one binary angle, Q(TRIG_FRAC_BITS) output.
// Depends on exr_pkg. Two stages per Horner step; enable stalls all stages.
module exr_sincos
    import exr_pkg::*;
#(
    parameter int ANGLE_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [ANGLE_WIDTH-1:0]   i_angle,
    output logic signed [31:0]       o_sin,
    output logic signed [31:0]       o_cos
);

    localparam int NST = 2 * COS_TERMS + 2;
    localparam int SH  = Q - TRIG_FRAC_BITS;
    localparam logic [31:0] ONE_Q30 = 32'h40000000;

    logic [2:0]  r_oct   [NST];
    logic [31:0] r_theta [NST];
    logic [31:0] r_x2    [2*COS_TERMS-1];
    logic [31:0] r_ps    [COS_TERMS];
    logic [31:0] r_pc    [COS_TERMS];
    logic [31:0] r_ts    [COS_TERMS+1];
    logic [31:0] r_tc    [COS_TERMS+1];
    logic [31:0] r_sn;
    logic [31:0] r_cs;
    logic [2:0]  r_octf;

    logic [31:0] n_a32;
    logic [28:0] n_frac;
    logic [63:0] n_th;

    // Octant reduction and angle scaling.
    always_comb begin
        n_a32  = 32'(i_angle) << (32 - ANGLE_WIDTH);
        n_frac = n_a32[29] ? 29'(30'h20000000 - {1'b0, n_a32[28:0]}) : n_a32[28:0];
        if (n_a32[29] && n_a32[28:0] == '0) n_th = 64'(PI_OVER_4_Q32) << 29;
        else n_th = {35'd0, n_frac} * {32'd0, PI_OVER_4_Q32};
        n_th = n_th + 64'h40000000;
    end

    // Each Horner step takes a product stage and a divide stage. Once the
    // sine series is done, its term just rides along beside the cosine.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct[0]   <= n_a32[31:29];
            r_theta[0] <= n_th[62:31];
            for (int s = 1; s < NST; s++) begin
                r_oct[s]   <= r_oct[s-1];
                r_theta[s] <= r_theta[s-1];
            end
            r_x2[0] <= mul_q30(r_theta[0], r_theta[0]);
            for (int k = 1; k < 2 * COS_TERMS - 1; k++) r_x2[k] <= r_x2[k-1];
            r_ts[0] <= ONE_Q30;
            r_tc[0] <= ONE_Q30;
            for (int j = 0; j < COS_TERMS; j++) begin
                r_ps[j]   <= (j < SIN_TERMS) ? mul_q30(r_x2[2*j], r_ts[j]) : r_ts[j];
                r_pc[j]   <= mul_q30(r_x2[2*j], r_tc[j]);
                r_ts[j+1] <= (j < SIN_TERMS)
                    ? ONE_Q30 - rnd_div(r_ps[j], sin_div(j))
                    : r_ps[j];
                r_tc[j+1] <= ONE_Q30 - rnd_div(r_pc[j], cos_div(j));
            end
            r_sn   <= mul_q30(r_theta[NST-1], r_ts[COS_TERMS]);
            r_cs   <= r_tc[COS_TERMS];
            r_octf <= r_oct[NST-1];
        end
    end

    logic [31:0] n_sr, n_cr;
    logic signed [32:0] n_s, n_c;

    // Quadrant fold and rounding to the output format.
    always_comb begin
        n_sr = r_octf[0] ? r_cs : r_sn;
        n_cr = r_octf[0] ? r_sn : r_cs;
        case (r_octf[2:1])
            2'd0: begin n_s = 33'(n_sr); n_c = 33'(n_cr); end
            2'd1: begin n_s = 33'(n_cr); n_c = -33'(n_sr); end
            2'd2: begin n_s = -33'(n_sr); n_c = -33'(n_cr); end
            default: begin n_s = -33'(n_cr); n_c = 33'(n_sr); end
        endcase
        if (SH > 0) begin
            n_s = (n_s + 33'(1 << (SH > 0 ? SH - 1 : 0))) >>> SH;
            n_c = (n_c + 33'(1 << (SH > 0 ? SH - 1 : 0))) >>> SH;
        end
        o_sin = n_s[31:0];
        o_cos = n_c[31:0];
    end

endmodule

/* rtl/euler_xyz_vector_rotation.sv */
// Top level of the Euler x-y-z point rotation pipeline.
// Depends on exr_pkg and exr_sincos.
//
// Usage: each input item carries a point (x, y, z) and three binary angles;
// each result item carries R * p, with R = Rx*Ry*Rz, rounded to nearest and
// saturated, and a clipped flag when any component hit a limit.
// Channels use valid/ready; an item moves on a cycle with both high.
// An accepted item passes 19 register stages, the first loaded at the edge
// that accepts it: 15 in the sine/cosine units (angle scaling, the square,
// two for each of the six Horner steps, the final sine product), two for the
// matrix products, one for the coordinate products and the output register.
// Throughput: one item per cycle. The whole pipeline advances as one unit
// when the output register is empty or being taken, so a stall at the
// receiver freezes every stage and nothing is lost or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module euler_xyz_vector_rotation
    import exr_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int ANGLE_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x_in,
    input  logic signed [COORD_WIDTH-1:0] i_y_in,
    input  logic signed [COORD_WIDTH-1:0] i_z_in,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_x,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_y,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_x_out,
    output logic signed [COORD_WIDTH-1:0] o_y_out,
    output logic signed [COORD_WIDTH-1:0] o_z_out,
    output logic                          o_clipped
);

    localparam int TRIG_LAT = 2 * COS_TERMS + 3;
    localparam int LAT      = TRIG_LAT + 4;
    localparam int F        = TRIG_FRAC_BITS;
    localparam int PW       = 2 * F + 6;
    localparam int AW       = PW + COORD_WIDTH + 2;

    logic          w_en;
    logic [LAT-1:0] r_vld;
    logic signed [COORD_WIDTH-1:0] r_p [TRIG_LAT][3];

    // The whole pipeline moves when the last stage can hand over.
    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Coordinates travel beside the trig pipeline.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0][0] <= i_x_in;
            r_p[0][1] <= i_y_in;
            r_p[0][2] <= i_z_in;
            for (int k = 1; k < TRIG_LAT; k++) r_p[k] <= r_p[k-1];
        end
    end

    logic signed [31:0] w_sa, w_ca, w_sb, w_cb, w_sg, w_cg;

    exr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(F)) u_ax (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_x), .o_sin(w_sa), .o_cos(w_ca));
    exr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(F)) u_ay (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_y), .o_sin(w_sb), .o_cos(w_cb));
    exr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(F)) u_az (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_z), .o_sin(w_sg), .o_cos(w_cg));

    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v);
        return (v + (64'sd1 <<< (F - 1))) >>> F;
    endfunction

    // Stage A: Rx*Ry products.
    logic signed [31:0] r_rxy [3][3];
    logic signed [31:0] r_sg, r_cg;
    logic signed [COORD_WIDTH-1:0] r_pa [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rxy[0][0] <= w_cb;
            r_rxy[0][1] <= '0;
            r_rxy[0][2] <= -w_sb;
            r_rxy[1][0] <= 32'(rnd_sh(64'(w_sa) * 64'(w_sb)));
            r_rxy[1][1] <= w_ca;
            r_rxy[1][2] <= 32'(rnd_sh(64'(w_sa) * 64'(w_cb)));
            r_rxy[2][0] <= 32'(rnd_sh(64'(w_ca) * 64'(w_sb)));
            r_rxy[2][1] <= -w_sa;
            r_rxy[2][2] <= 32'(rnd_sh(64'(w_ca) * 64'(w_cb)));
            r_sg <= w_sg;
            r_cg <= w_cg;
            r_pa <= r_p[TRIG_LAT-1];
        end
    end

    // Stage B: product with Rz.
    logic signed [31:0] r_m [3][3];
    logic signed [COORD_WIDTH-1:0] r_pb [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i][0] <= 32'(rnd_sh(64'(r_rxy[i][0]) * 64'(r_cg)
                                        - 64'(r_rxy[i][1]) * 64'(r_sg)));
                r_m[i][1] <= 32'(rnd_sh(64'(r_rxy[i][0]) * 64'(r_sg)
                                        + 64'(r_rxy[i][1]) * 64'(r_cg)));
                r_m[i][2] <= r_rxy[i][2];
            end
            r_pb <= r_pa;
        end
    end

    // Stage C: nine coefficient-by-coordinate products.
    logic signed [PW+COORD_WIDTH-1:0] r_prod [3][3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r_prod[i][j] <= (PW+COORD_WIDTH)'(r_m[i][j]) *
                                    (PW+COORD_WIDTH)'(r_pb[j]);
        end
    end

    // Stage D: sum, round and saturate each component.
    logic signed [AW-1:0] n_acc [3];
    logic signed [AW-1:0] n_q [3];
    logic signed [COORD_WIDTH-1:0] n_o [3];
    logic [2:0] n_clip;
    localparam logic signed [AW-1:0] MAXV = (AW'(1) <<< (COORD_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] MINV = -(AW'(1) <<< (COORD_WIDTH - 1));
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = AW'(r_prod[i][0]) + AW'(r_prod[i][1]) + AW'(r_prod[i][2])
                       + (AW'(1) <<< (F - 1));
            n_q[i]   = n_acc[i] >>> F;
            n_clip[i] = (n_q[i] > MAXV) || (n_q[i] < MINV);
            n_o[i]   = (n_q[i] > MAXV) ? MAXV[COORD_WIDTH-1:0]
                     : (n_q[i] < MINV) ? MINV[COORD_WIDTH-1:0]
                     : n_q[i][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_x_out   <= n_o[0];
            o_y_out   <= n_o[1];
            o_z_out   <= n_o[2];
            o_clipped <= |n_clip;
        end
    end

    // A stalled result must stay put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_out) && $stable(o_clipped))
        else $error("result changed while stalled");
    // Ready follows the output stage.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");
    // An accepted item enters the first valid stage.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted item lost");

endmodule
